// ----- hdl/frs_pkg.sv -----
// types, constants and match functions shared by the flow rule overlap scanner
`default_nettype none

package frs_pkg;

   localparam int unsigned ADDR_BITS = 32;
   localparam logic [7:0] WILDCARD_PROTO = 8'h00;

   typedef struct packed {
      logic        mode;
      logic [7:0]  entry;
      logic [31:0] source_address;
      logic [5:0]  source_length;
      logic [31:0] dest_address;
      logic [5:0]  dest_length;
      logic [15:0] source_port_low;
      logic [15:0] source_port_high;
      logic [15:0] dest_port_low;
      logic [15:0] dest_port_high;
      logic [7:0]  protocol_number;
   } req_item_type;

   typedef struct packed {
      logic [7:0] overlap_count;
      logic [8:0] first_overlap;
      logic [8:0] last_overlap;
   } rsp_item_type;

   // one stored rule, as kept in the rule memory
   typedef struct packed {
      logic [31:0] src_addr;
      logic [31:0] dst_addr;
      logic [5:0]  src_len;
      logic [5:0]  dst_len;
      logic [15:0] sp_lo;
      logic [15:0] sp_hi;
      logic [15:0] dp_lo;
      logic [15:0] dp_hi;
      logic [7:0]  proto;
   } rule_type;

   localparam int unsigned RULE_W = $bits(rule_type);

   typedef enum logic [1:0] {
      CMD_LOAD  = 2'd0,
      CMD_QUERY = 2'd1,
      CMD_NULL  = 2'd2
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [7:0]   entry;
      rule_type     rule;
   } cmd_type;

   localparam logic MODE_LOAD = 1'b0;

   function automatic logic ranges_meet(logic [15:0] alo, logic [15:0] ahi,
                                        logic [15:0] blo, logic [15:0] bhi);
      return !((ahi < blo) || (bhi < alo));
   endfunction

   // shorter prefix length decides, lengths above the address width act as full
   function automatic logic prefixes_meet(logic [31:0] a, logic [5:0] la,
                                          logic [31:0] b, logic [5:0] lb);
      logic [5:0]  len;
      logic [31:0] mask;
      len = (la < lb) ? la : lb;
      if (len > 6'(ADDR_BITS)) len = 6'(ADDR_BITS);
      mask = ~({ADDR_BITS{1'b1}} >> len);
      return ((a ^ b) & mask) == '0;
   endfunction

   function automatic logic rule_overlap(rule_type q, rule_type o);
      logic proto_ok;
      proto_ok = (q.proto == o.proto) || (q.proto == WILDCARD_PROTO)
               || (o.proto == WILDCARD_PROTO);
      return proto_ok
         && ranges_meet(q.sp_lo, q.sp_hi, o.sp_lo, o.sp_hi)
         && ranges_meet(q.dp_lo, q.dp_hi, o.dp_lo, o.dp_hi)
         && prefixes_meet(q.src_addr, q.src_len, o.src_addr, o.src_len)
         && prefixes_meet(q.dst_addr, q.dst_len, o.dst_addr, o.dst_len);
   endfunction

   function automatic logic rule_same(rule_type q, rule_type o);
      return q == o;
   endfunction

endpackage

`default_nettype wire

// ----- hdl/frs_ram.sv -----
// generic single write, single registered read memory
`default_nettype none

module frs_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 16,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output      logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- hdl/frs_front.sv -----
// front end: takes items, classifies them and queues commands for the scan engine
`default_nettype none

module frs_front import frs_pkg::*; #(
   parameter int TABLE_ENTRIES = 256
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         push,
   output      logic         full,
   input  wire req_item_type req_item,
   output      logic         cmd_valid,
   output      cmd_type      cmd,
   input  wire logic         cmd_pop
);

   cmd_type     cmd_q_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;
   logic        in_range;
   logic        do_push;
   cmd_type     new_cmd;

   assign full      = (count_ff == 2'd2);
   assign cmd_valid = (count_ff != 2'd0);
   assign cmd       = cmd_q_ff[rd_ptr_ff];

   always_comb begin
      in_range = 32'(req_item.entry) < TABLE_ENTRIES;
      new_cmd.entry = req_item.entry;
      new_cmd.rule.src_addr = req_item.source_address;
      new_cmd.rule.dst_addr = req_item.dest_address;
      new_cmd.rule.src_len  = req_item.source_length;
      new_cmd.rule.dst_len  = req_item.dest_length;
      new_cmd.rule.sp_lo    = req_item.source_port_low;
      new_cmd.rule.sp_hi    = req_item.source_port_high;
      new_cmd.rule.dp_lo    = req_item.dest_port_low;
      new_cmd.rule.dp_hi    = req_item.dest_port_high;
      new_cmd.rule.proto    = req_item.protocol_number;
      if (req_item.mode == MODE_LOAD) begin
         new_cmd.kind = CMD_LOAD;
      end else if (in_range) begin
         new_cmd.kind = CMD_QUERY;
      end else begin
         new_cmd.kind = CMD_NULL;
      end
      // a load beyond the table is dropped here
      do_push = push && !full && !((req_item.mode == MODE_LOAD) && !in_range);

      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = (cmd_pop && cmd_valid) ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(do_push) - 2'(cmd_pop && cmd_valid);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         cmd_q_ff[wr_ptr_ff] <= new_cmd;
      end
   end

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("command queue count out of range");
`endif

endmodule

`default_nettype wire

// ----- hdl/frs_scan.sv -----
// back end: executes loads and scans the rule memory for queries
`default_nettype none

module frs_scan import frs_pkg::*; #(
   parameter int TABLE_ENTRIES = 256
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic [8:0]   rules_in_use,
   input  wire logic         cmd_valid,
   input  wire cmd_type      cmd,
   output      logic         cmd_pop,
   output      logic         res_valid,
   output      rsp_item_type res,
   input  wire logic         res_ready
);

   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int LIM_W = $clog2(TABLE_ENTRIES + 1);

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_FETCH = 4'b0010,
      S_SCAN  = 4'b0100,
      S_DONE  = 4'b1000
   } state_type;

   state_type        state_ff, state_in;
   logic [LIM_W-1:0] limit_ff, limit_in;
   logic [LIM_W-1:0] issue_ff, issue_in;
   logic [IDX_W-1:0] q_idx_ff, q_idx_in;
   rule_type         q_rule_ff, q_rule_in;
   logic             v1_ff, v1_in;
   logic [IDX_W-1:0] idx1_ff, idx1_in;
   logic             v2_ff, v2_in;
   logic             hit2_ff, hit2_in;
   logic [IDX_W-1:0] idx2_ff, idx2_in;
   logic [7:0]       count_ff, count_in;
   logic [8:0]       first_ff, first_in;
   logic [8:0]       last_ff, last_in;

   logic             wr_en, rd_en;
   logic [IDX_W-1:0] rd_addr;
   logic [RULE_W-1:0] rd_data;
   rule_type         o_rule;
   logic [LIM_W-1:0] limit_c;
   logic [IDX_W:0]   idx_plus;
   logic             issuing;

   frs_ram #(
      .WIDTH (RULE_W),
      .DEPTH (TABLE_ENTRIES),
      .ADDR_W(IDX_W)
   ) u_rules (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(IDX_W'(cmd.entry)),
      .wr_data(cmd.rule),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign o_rule    = rule_type'(rd_data);
   assign res_valid = (state_ff == S_DONE);
   assign res.overlap_count = count_ff;
   assign res.first_overlap = first_ff;
   assign res.last_overlap  = last_ff;

   always_comb begin
      limit_c = (32'(rules_in_use) > TABLE_ENTRIES) ? LIM_W'(TABLE_ENTRIES)
                                                    : LIM_W'(rules_in_use);
      state_in  = state_ff;
      limit_in  = limit_ff;
      issue_in  = issue_ff;
      q_idx_in  = q_idx_ff;
      q_rule_in = q_rule_ff;
      count_in  = count_ff;
      first_in  = first_ff;
      last_in   = last_ff;
      cmd_pop   = 1'b0;
      wr_en     = 1'b0;
      rd_en     = 1'b0;
      rd_addr   = issue_ff[IDX_W-1:0];
      issuing   = 1'b0;

      // compare stage on the entry read last cycle
      v2_in   = v1_ff;
      idx2_in = idx1_ff;
      hit2_in = rule_overlap(q_rule_ff, o_rule) && !rule_same(q_rule_ff, o_rule)
              && (idx1_ff != q_idx_ff);

      // accumulate stage
      idx_plus = {1'b0, idx2_ff} + (IDX_W+1)'(1);
      if (v2_ff && hit2_ff) begin
         if (count_ff != 8'hFF) count_in = count_ff + 8'd1;
         if (first_ff == 9'd0) first_in = 9'(idx_plus);
         last_in = 9'(idx_plus);
      end

      unique case (state_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               cmd_pop = 1'b1;
               case (cmd.kind)
                  CMD_LOAD: begin
                     wr_en = 1'b1;
                  end
                  CMD_QUERY: begin
                     rd_en    = 1'b1;
                     rd_addr  = IDX_W'(cmd.entry);
                     q_idx_in = IDX_W'(cmd.entry);
                     limit_in = limit_c;
                     issue_in = '0;
                     count_in = '0;
                     first_in = '0;
                     last_in  = '0;
                     state_in = S_FETCH;
                  end
                  CMD_NULL: begin
                     count_in = '0;
                     first_in = '0;
                     last_in  = '0;
                     state_in = S_DONE;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_FETCH: begin
            q_rule_in = o_rule;
            state_in  = S_SCAN;
         end
         S_SCAN: begin
            if (issue_ff < limit_ff) begin
               issuing  = 1'b1;
               rd_en    = 1'b1;
               issue_in = issue_ff + LIM_W'(1);
            end else if (!v1_ff && !v2_ff) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (res_ready) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      v1_in   = issuing;
      idx1_in = issue_ff[IDX_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         v1_ff    <= v1_in;
         v2_ff    <= v2_in;
      end
      limit_ff  <= limit_in;
      issue_ff  <= issue_in;
      q_idx_ff  <= q_idx_in;
      q_rule_ff <= q_rule_in;
      idx1_ff   <= idx1_in;
      hit2_ff   <= hit2_in;
      idx2_ff   <= idx2_in;
      count_ff  <= count_in;
      first_ff  <= first_in;
      last_ff   <= last_in;
   end

`ifndef NO_ASSERTIONS
   a_drained: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE) |-> (!v1_ff && !v2_ff))
      else $error("result shown before the scan pipeline drained");

   a_none_zero: assert property (@(posedge clock) disable iff (reset)
      (res_valid && (first_ff == 9'd0)) |-> ((count_ff == 8'd0) && (last_ff == 9'd0)))
      else $error("overlap count without an overlapping entry");

   a_order: assert property (@(posedge clock) disable iff (reset)
      (res_valid && (first_ff != 9'd0)) |-> ((last_ff >= first_ff) && (count_ff != 8'd0)))
      else $error("first and last overlap out of order");
`endif

endmodule

`default_nettype wire

// ----- hdl/flow_rule_overlap_scanner.sv -----
// top level of the flow rule overlap scanner
`default_nettype none

// channel    ports                          direction  accepted when
// request    push, full, req_item           in         push && !full
// response   empty, pop, rsp_item           out        pop && !empty
// csr        csr_we, csr_wdata              in         csr_we
//
// a load is taken by the scan engine in its idle state; a query holds it while it scans rules_in_use entries
// (capped at the table size), one entry per cycle through the rule memory read port
// the front queue holds two commands, so items are taken while the engine works
// and while a finished response waits in the output register
// reset is synchronous; the rule memory is not cleared and needs no sweep
// a stalled response holds the engine in its done state, the front still fills

module flow_rule_overlap_scanner import frs_pkg::*; #(
   parameter int TABLE_ENTRIES = 256
) (
   input  wire logic         clock,
   input  wire logic         reset,
   // request side
   input  wire logic         push,
   output      logic         full,
   input  wire req_item_type req_item,
   // response side
   output      logic         empty,
   input  wire logic         pop,
   output      rsp_item_type rsp_item,
   // register write
   input  wire logic         csr_we,
   input  wire logic [8:0]   csr_wdata
);

   // number of entries taking part in queries
   logic [8:0]   rules_in_use_ff, rules_in_use_in;

   // front to back command hand-off
   logic         cmd_valid;
   cmd_type      cmd;
   logic         cmd_pop;

   // back to output register
   logic         res_valid;
   rsp_item_type res;
   logic         res_ready;

   // output register
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_item_type rsp_item_ff, rsp_item_in;

   frs_front #(
      .TABLE_ENTRIES(TABLE_ENTRIES)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_item (req_item),
      .cmd_valid(cmd_valid),
      .cmd      (cmd),
      .cmd_pop  (cmd_pop)
   );

   frs_scan #(
      .TABLE_ENTRIES(TABLE_ENTRIES)
   ) u_scan (
      .clock       (clock),
      .reset       (reset),
      .rules_in_use(rules_in_use_ff),
      .cmd_valid   (cmd_valid),
      .cmd         (cmd),
      .cmd_pop     (cmd_pop),
      .res_valid   (res_valid),
      .res         (res),
      .res_ready   (res_ready)
   );

   // output slot frees up in the same cycle it is popped
   assign res_ready = !rsp_valid_ff || pop;

   always_comb begin
      rules_in_use_in = csr_we ? csr_wdata : rules_in_use_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_item_in     = rsp_item_ff;
      if (res_valid && res_ready) begin
         rsp_valid_in = 1'b1;
         rsp_item_in  = res;
      end else if (pop && rsp_valid_ff) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rules_in_use_ff <= 9'd0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         rules_in_use_ff <= rules_in_use_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      rsp_item_ff <= rsp_item_in;
   end

   assign empty    = !rsp_valid_ff;
   assign rsp_item = rsp_item_ff;

endmodule

`default_nettype wire

// ----- tb/flow_rule_overlap_scanner_checker.sv -----
// checker for the flow rule overlap scanner: shadow rule table, scan prediction, response compare
`timescale 1ns / 100ps

module flow_rule_overlap_scanner_checker import frs_pkg::*; #(
   parameter int TABLE_ENTRIES = 256
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  logic         full,
   input  req_item_type req_item,
   input  logic         empty,
   input  logic         pop,
   input  rsp_item_type rsp_item,
   input  logic         csr_we,
   input  logic [8:0]   csr_wdata,
   output int           fail_count,
   output int           outstanding
);

   rule_type     shadow_rules [TABLE_ENTRIES];
   logic [8:0]   rules_in_use;
   rsp_item_type pending_scans [$];
   int           errors = 0;

   function automatic bit ports_cross(logic [15:0] a_lo, logic [15:0] a_hi,
                                      logic [15:0] b_lo, logic [15:0] b_hi);
      return (a_hi >= b_lo) && (b_hi >= a_lo);
   endfunction

   // compare only the bits of the shorter prefix, lengths past 32 count as 32
   function automatic bit prefix_agree(logic [31:0] a, logic [5:0] a_len,
                                       logic [31:0] b, logic [5:0] b_len);
      int unsigned n;
      n = (a_len < b_len) ? a_len : b_len;
      if (n > 32) n = 32;
      if (n == 0) return 1'b1;
      return (a >> (32 - n)) == (b >> (32 - n));
   endfunction

   function automatic rsp_item_type scan_for_overlaps(logic [7:0] q_entry);
      rsp_item_type found;
      rule_type     q;
      rule_type     o;
      int unsigned  span;
      int unsigned  hits;
      bit           meet;
      found = '0;
      hits  = 0;
      if (q_entry >= TABLE_ENTRIES) return found;
      q    = shadow_rules[q_entry];
      span = (rules_in_use > TABLE_ENTRIES) ? TABLE_ENTRIES : rules_in_use;
      for (int j = 0; j < span; j++) begin
         if (j == int'(q_entry)) continue;
         o = shadow_rules[j];
         meet = (q.proto == o.proto || q.proto == WILDCARD_PROTO || o.proto == WILDCARD_PROTO)
             && ports_cross(q.sp_lo, q.sp_hi, o.sp_lo, o.sp_hi)
             && ports_cross(q.dp_lo, q.dp_hi, o.dp_lo, o.dp_hi)
             && prefix_agree(q.src_addr, q.src_len, o.src_addr, o.src_len)
             && prefix_agree(q.dst_addr, q.dst_len, o.dst_addr, o.dst_len);
         if (meet && (q != o)) begin
            if (hits < 255) hits++;
            if (found.first_overlap == '0) found.first_overlap = 9'(j + 1);
            found.last_overlap = 9'(j + 1);
         end
      end
      found.overlap_count = 8'(hits);
      return found;
   endfunction

   always @(posedge clock) begin
      rsp_item_type want;
      rule_type     loaded;
      if (reset) begin
         rules_in_use = '0;
         pending_scans.delete();
      end else begin
         if (pop && !empty) begin
            if (pending_scans.size() == 0) begin
               $error("response with no query waiting: overlap_count %0d first %0d last %0d",
                      rsp_item.overlap_count, rsp_item.first_overlap, rsp_item.last_overlap);
               errors++;
            end else begin
               want = pending_scans.pop_front();
               if (rsp_item.overlap_count !== want.overlap_count) begin
                  $error("overlap_count: expected %0d, got %0d",
                         want.overlap_count, rsp_item.overlap_count);
                  errors++;
               end
               if (rsp_item.first_overlap !== want.first_overlap) begin
                  $error("first_overlap: expected %0d, got %0d",
                         want.first_overlap, rsp_item.first_overlap);
                  errors++;
               end
               if (rsp_item.last_overlap !== want.last_overlap) begin
                  $error("last_overlap: expected %0d, got %0d",
                         want.last_overlap, rsp_item.last_overlap);
                  errors++;
               end
            end
         end
         if (csr_we) rules_in_use = csr_wdata;
         if (push && !full) begin
            if (req_item.mode == MODE_LOAD) begin
               loaded.src_addr = req_item.source_address;
               loaded.dst_addr = req_item.dest_address;
               loaded.src_len  = req_item.source_length;
               loaded.dst_len  = req_item.dest_length;
               loaded.sp_lo    = req_item.source_port_low;
               loaded.sp_hi    = req_item.source_port_high;
               loaded.dp_lo    = req_item.dest_port_low;
               loaded.dp_hi    = req_item.dest_port_high;
               loaded.proto    = req_item.protocol_number;
               if (req_item.entry < TABLE_ENTRIES) shadow_rules[req_item.entry] = loaded;
            end else begin
               pending_scans = {pending_scans, scan_for_overlaps(req_item.entry)};
            end
         end
      end
      fail_count  <= errors;
      outstanding <= pending_scans.size();
   end

endmodule

// ----- tb/flow_rule_overlap_scanner_tb.sv -----
// testbench top for the flow rule overlap scanner: stimulus, flow control and verdict
`timescale 1ns / 100ps

module flow_rule_overlap_scanner_tb import frs_pkg::*; ();

   localparam int   TABLE_ENTRIES = 256;
   localparam logic MODE_QUERY    = ~MODE_LOAD;

   // a query scans at most the full table, so DRAIN_CYCLES covers the slowest one
   localparam int DRAIN_CYCLES  = 300;
   // loads give no response, a few may still sit in the front queue
   localparam int SETTLE_CYCLES = 16;
   // long receiver hold-off, counted by the receiver itself
   localparam int HOLD_CYCLES   = 800;
   // hold-off + a full-table scan + the longest gaps, taken a few times over
   localparam int QUIET_LIMIT   = 5000;
   localparam int PHASES        = 12;
   localparam int PHASE_ITEMS   = 60;
   localparam int HOLD_PHASE    = 5;

   logic         clock;
   logic         reset     = 1'b1;
   logic         push      = 1'b0;
   logic         full;
   req_item_type req_item  = '0;
   logic         empty;
   logic         pop       = 1'b0;
   rsp_item_type rsp_item;
   logic         csr_we    = 1'b0;
   logic [8:0]   csr_wdata = '0;

   int fail_count;
   int outstanding;

   // stimulus-side copy of every loaded rule, used to make exact duplicates
   req_item_type rule_book [TABLE_ENTRIES];
   bit           written   [TABLE_ENTRIES];

   // sender burst state; steady turns the gaps off for a phase
   int unsigned burst_left = 0;
   bit          steady     = 1'b0;
   // asks the receiver for one long hold-off
   bit          hold_req   = 1'b0;

   flow_rule_overlap_scanner #(
      .TABLE_ENTRIES(TABLE_ENTRIES)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_item  (req_item),
      .empty     (empty),
      .pop       (pop),
      .rsp_item  (rsp_item),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   flow_rule_overlap_scanner_checker #(
      .TABLE_ENTRIES(TABLE_ENTRIES)
   ) u_checker (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .full        (full),
      .req_item    (req_item),
      .empty       (empty),
      .pop         (pop),
      .rsp_item    (rsp_item),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // ---------------------------------------------------------------- rule makers

   function automatic req_item_type rule_of(logic [7:0] slot,
                                            logic [31:0] sa, logic [5:0] sl,
                                            logic [31:0] da, logic [5:0] dl,
                                            logic [15:0] sp_lo, logic [15:0] sp_hi,
                                            logic [15:0] dp_lo, logic [15:0] dp_hi,
                                            logic [7:0] proto);
      req_item_type r;
      r.mode             = MODE_LOAD;
      r.entry            = slot;
      r.source_address   = sa;
      r.source_length    = sl;
      r.dest_address     = da;
      r.dest_length      = dl;
      r.source_port_low  = sp_lo;
      r.source_port_high = sp_hi;
      r.dest_port_low    = dp_lo;
      r.dest_port_high   = dp_hi;
      r.protocol_number  = proto;
      return r;
   endfunction

   // addresses cluster in a few private nets so prefixes actually collide
   function automatic logic [31:0] pick_address();
      logic [31:0] host;
      host = $urandom & (($urandom_range(0, 1) != 0) ? 32'h0000_00FF : 32'h0000_FFFF);
      case ($urandom_range(0, 3))
         0:       return $urandom;
         1:       return 32'h0A00_0000 | host;
         2:       return 32'hC0A8_0000 | host;
         default: return 32'hAC10_0000 | host;
      endcase
   endfunction

   // mostly short prefixes, now and then a length past 32
   function automatic logic [5:0] pick_length();
      case ($urandom_range(0, 9))
         0:       return 6'd0;
         1:       return 6'd8;
         2, 3:    return 6'd16;
         4:       return 6'd24;
         5:       return 6'd32;
         6, 7:    return 6'($urandom_range(0, 32));
         8:       return 6'($urandom_range(33, 63));
         default: return 6'($urandom_range(0, 16));
      endcase
   endfunction

   // {low, high}: wide, low ports, random, inverted, or one well-known port
   function automatic logic [31:0] pick_ports();
      logic [15:0] a;
      logic [15:0] b;
      a = 16'($urandom);
      b = 16'($urandom);
      case ($urandom_range(0, 11))
         0, 1, 2: return {16'h0000, 16'hFFFF};
         3, 4, 5: begin
            a = 16'($urandom_range(0, 1023));
            return {a, 16'($urandom_range(a, 2047))};
         end
         6, 7:    return (a <= b) ? {a, b} : {b, a};
         8:       return (a > b) ? {a, b} : {b, a};
         default: begin
            case ($urandom_range(0, 3))
               0:       a = 16'd22;
               1:       a = 16'd53;
               2:       a = 16'd80;
               default: a = 16'd443;
            endcase
            return {a, a};
         end
      endcase
   endfunction

   function automatic logic [7:0] pick_protocol();
      case ($urandom_range(0, 3))
         0:       return WILDCARD_PROTO;
         1:       return 8'd6;
         2:       return 8'd17;
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic req_item_type make_rule(logic [7:0] slot);
      req_item_type r;
      int unsigned  twin;
      twin = $urandom_range(0, TABLE_ENTRIES - 1);
      // exact duplicates, sometimes nudged by one address bit
      if (written[twin] && $urandom_range(0, 7) == 0) begin
         r       = rule_book[twin];
         r.entry = slot;
         if ($urandom_range(0, 1) != 0) r.source_address[0] = ~r.source_address[0];
         return r;
      end
      r.mode            = MODE_LOAD;
      r.entry           = slot;
      r.source_address  = pick_address();
      r.dest_address    = pick_address();
      r.source_length   = pick_length();
      r.dest_length     = pick_length();
      r.protocol_number = pick_protocol();
      {r.source_port_low, r.source_port_high} = pick_ports();
      {r.dest_port_low, r.dest_port_high}     = pick_ports();
      return r;
   endfunction

   // a query carries noise in every field the block ignores
   function automatic req_item_type make_query(logic [7:0] slot);
      req_item_type r;
      r.mode             = MODE_QUERY;
      r.entry            = slot;
      r.source_address   = $urandom;
      r.source_length    = 6'($urandom);
      r.dest_address     = $urandom;
      r.dest_length      = 6'($urandom);
      r.source_port_low  = 16'($urandom);
      r.source_port_high = 16'($urandom);
      r.dest_port_low    = 16'($urandom);
      r.dest_port_high   = 16'($urandom);
      r.protocol_number  = 8'($urandom);
      return r;
   endfunction

   // mostly inside the scanned range, sometimes anywhere in the table
   function automatic logic [7:0] pick_slot(int unsigned scope);
      int unsigned span;
      span = (scope > TABLE_ENTRIES) ? TABLE_ENTRIES : scope;
      if (span > 0 && $urandom_range(0, 3) != 0) return 8'($urandom_range(0, span - 1));
      return 8'($urandom_range(0, TABLE_ENTRIES - 1));
   endfunction

   // ---------------------------------------------------------------- sender

   // one item per call; bursts of random length with random gaps in between
   task automatic offer_item(input req_item_type it);
      int unsigned gap;
      if (burst_left == 0) begin
         gap        = (steady || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         burst_left = $urandom_range(1, 40);
         if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      push     <= 1'b1;
      req_item <= it;
      do @(posedge clock); while (full);
      if (it.mode == MODE_LOAD) begin
         rule_book[it.entry] = it;
         written[it.entry]   = 1'b1;
      end
   endtask

   // stop offering, let every query come back, then give trailing loads time
   task automatic drain_block();
      push <= 1'b0;
      // let the checker count the last accepted item before outstanding is read
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // rules_in_use is only written with the block idle
   task automatic set_scope(input logic [8:0] value);
      drain_block();
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   // ---------------------------------------------------------------- receiver

   // stall styles change at random intervals; one long hold-off on request
   initial begin : receiver
      int unsigned hold_left;
      int unsigned style;
      int unsigned style_left;
      int unsigned tick;
      bit          hold_taken;
      hold_left  = 0;
      style      = 0;
      style_left = 0;
      tick       = 0;
      hold_taken = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         @(posedge clock);
         tick++;
         if (hold_req && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left  = HOLD_CYCLES;
         end
         if (style_left == 0) begin
            style      = $urandom_range(0, 3);
            style_left = $urandom_range(20, 200);
         end
         style_left--;
         if (hold_left > 0) begin
            hold_left--;
            pop <= 1'b0;
         end else begin
            case (style)
               0:       pop <= 1'b1;
               1:       pop <= ($urandom_range(0, 1) != 0);
               2:       pop <= ($urandom_range(0, 3) == 0);
               default: pop <= tick[3];
            endcase
         end
      end
   end

   // ---------------------------------------------------------------- watchdog

   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((push && !full) || (pop && !empty)) quiet = 0;
         else quiet++;
      end
      $display("flow_rule_overlap_scanner_tb NOT OK");
      $finish;
   end

   // ---------------------------------------------------------------- stimulus

   initial begin : stimulus
      int unsigned scope;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: hand-made rules in entries 0..7, each queried in turn
      set_scope(9'd8);
      // tcp to one web port from a /8 into a /24
      offer_item(rule_of(8'd0, 32'h0A00_0000, 6'd8, 32'hC0A8_0100, 6'd24,
                         16'd0, 16'hFFFF, 16'd80, 16'd80, 8'd6));
      // identical copy of entry 0, never reported against it
      offer_item(rule_of(8'd1, 32'h0A00_0000, 6'd8, 32'hC0A8_0100, 6'd24,
                         16'd0, 16'hFFFF, 16'd80, 16'd80, 8'd6));
      // host rule under the same nets with a wildcard protocol
      offer_item(rule_of(8'd2, 32'h0A01_0203, 6'd32, 32'hC0A8_014D, 6'd32,
                         16'd1024, 16'd2047, 16'd0, 16'd100, WILDCARD_PROTO));
      // zero-length prefixes match any address, disjoint ports
      offer_item(rule_of(8'd3, 32'h0000_0000, 6'd0, 32'h0000_0000, 6'd0,
                         16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 8'd17));
      // inverted source range and lengths past 32
      offer_item(rule_of(8'd4, 32'h0A7F_0000, 6'd40, 32'hC0A8_0105, 6'd63,
                         16'd500, 16'd100, 16'd50, 16'd90, 8'd6));
      // every address, port and protocol at its top value
      offer_item(rule_of(8'd5, 32'hFFFF_FFFF, 6'd32, 32'hFFFF_FFFF, 6'd32,
                         16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'd255));
      // addresses and ports at zero, same protocol as entry 5
      offer_item(rule_of(8'd6, 32'h0000_0000, 6'd32, 32'h0000_0000, 6'd32,
                         16'd0, 16'd0, 16'd0, 16'd0, 8'd255));
      // like entry 0 but udp, protocols disagree
      offer_item(rule_of(8'd7, 32'h0A00_0000, 6'd8, 32'hC0A8_0100, 6'd24,
                         16'd0, 16'hFFFF, 16'd80, 16'd80, 8'd17));
      for (int e = 0; e < 8; e++) offer_item(make_query(8'(e)));
      // queried entry outside the scanned range is still compared
      set_scope(9'd4);
      offer_item(make_query(8'd6));
      offer_item(make_query(8'd0));
      // nothing in use: every query reports zero
      set_scope(9'd0);
      offer_item(make_query(8'd2));
      set_scope(9'd2);
      offer_item(make_query(8'd5));

      // fill the whole table so any entry may be scanned from here on
      for (int e = 0; e < TABLE_ENTRIES; e++) offer_item(make_rule(8'(e)));

      // random phases, each under its own rules_in_use
      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0:          scope = 2;
            1:          scope = 256;
            2:          scope = 511;
            3:          scope = 1;
            4:          scope = 300;
            HOLD_PHASE: scope = 6;
            default:    scope = $urandom_range(2, 40);
         endcase
         set_scope(9'(scope));
         steady = (p % 4 == 3) || (p == HOLD_PHASE);
         // receiver stops popping while the sender keeps pushing, the block backs up
         if (p == HOLD_PHASE) hold_req = 1'b1;
         repeat (PHASE_ITEMS) begin
            if ($urandom_range(0, 99) < 40) offer_item(make_rule(pick_slot(scope)));
            else offer_item(make_query(pick_slot(scope)));
         end
      end

      // every rule overlaps every other: count reaches its top value
      steady = 1'b0;
      for (int e = 0; e < TABLE_ENTRIES; e++)
         offer_item(rule_of(8'(e), 32'(e), 6'd0, $urandom, 6'd0,
                            16'd0, 16'hFFFF, 16'd0, 16'hFFFF, WILDCARD_PROTO));
      set_scope(9'd511);
      offer_item(make_query(8'd0));
      offer_item(make_query(8'd128));
      offer_item(make_query(8'd255));
      set_scope(9'd256);
      offer_item(make_query(8'd7));

      // wait out the last responses, then the scan latency
      push <= 1'b0;
      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && outstanding == 0) $display("flow_rule_overlap_scanner_tb OK");
      else $display("flow_rule_overlap_scanner_tb NOT OK");
      $finish;
   end

endmodule

// ----- filelist.f -----
hdl/frs_pkg.sv
hdl/frs_ram.sv
hdl/frs_front.sv
hdl/frs_scan.sv
hdl/flow_rule_overlap_scanner.sv
tb/flow_rule_overlap_scanner_checker.sv
tb/flow_rule_overlap_scanner_tb.sv
